[rtl/cidc_pkg.sv]
// Package for the CAN identifier occurrence counter.
// Table size, field widths, the cell entry and command types and the sequencer states.
// No dependencies.
package cidc_pkg;

  localparam int TABLE_ENTRIES = 12;

  localparam int ID_W   = 32;
  localparam int CNT_W  = 16;
  localparam int IDX_W  = 6;
  localparam int USED_W = 7;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_MSG,
    CELL_SHIFT
  } cidc_op_e;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
  } cidc_entry_t;

  typedef struct packed {
    cidc_op_e        op;
    logic [ID_W-1:0] id;
  } cidc_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } cidc_state_e;

endpackage

[rtl/cidc_cell.sv]
// One table cell: a stored identifier, its count and a valid bit.
// Depends on cidc_pkg. Shifts toward cell 0 while the table is read out.
module cidc_cell
  import cidc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cidc_ctrl_t  ctrl_i,
  input  logic        any_hit_i,
  input  logic        prev_valid_i,
  input  cidc_entry_t next_i,
  output cidc_entry_t entry_o,
  output logic        hit_o
);

  logic             valid_q, valid_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             claim;

  assign hit_o = valid_q && (id_q == ctrl_i.id);
  // first free cell after a filled run takes a new identifier
  assign claim = !valid_q && prev_valid_i && !any_hit_i;

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    count_d = count_q;
    case (ctrl_i.op)
      CELL_MSG: begin
        if (hit_o) begin
          count_d = count_q + CNT_W'(1);
        end else if (claim) begin
          valid_d = 1'b1;
          id_d    = ctrl_i.id;
          count_d = CNT_W'(1);
        end
      end
      CELL_SHIFT: begin
        valid_d = next_i.valid;
        id_d    = next_i.id;
        count_d = next_i.count;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    count_q <= count_d;
  end

  assign entry_o = '{valid: valid_q, id: id_q, count: count_q};

endmodule

[rtl/can_id_occurrence_counter.sv]
// Top level of the CAN identifier occurrence counter.
// Depends on cidc_pkg and cidc_cell (a row of TABLE_ENTRIES cells).
//
// Counts how often each distinct CAN identifier is seen in a window. A
// message beat (mode 0) has its identifier compared against
// every cell at once; a hit bumps that cell's 16-bit count (wrapping), a miss
// fills the next free cell with count one, and once the table is full new
// identifiers are dropped. An identifier of zero is ignored. A tick beat
// (mode 1) reports the table in order, one result beat per filled entry with
// last set on the final one, or one empty_res beat if nothing was seen, and
// leaves the table clear. Readout shifts the row of cells toward cell 0, one
// entry per cycle while the output is not stalled, so a tick holds the input
// off until the last entry has been read out; no input is taken meanwhile.
// An input beat is only taken while the output register is empty or being
// emptied in the same cycle, so a result left waiting holds the input off.
module can_id_occurrence_counter
  import cidc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [ID_W-1:0]   can_id_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  entry_index_o,
  output logic [ID_W-1:0]   entry_id_o,
  output logic [CNT_W-1:0]  entry_count_o,
  output logic [USED_W-1:0] entries_used_o,
  output logic              empty_res_o,
  output logic              last_o
);

  cidc_state_e state_q, state_d;

  cidc_ctrl_t  ctrl;
  cidc_entry_t cells [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hits;
  logic [TABLE_ENTRIES-1:0] valids;
  logic        any_hit;

  logic [USED_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  o_idx_q, o_idx_d;
  logic [ID_W-1:0]   o_id_q, o_id_d;
  logic [CNT_W-1:0]  o_cnt_q, o_cnt_d;
  logic [USED_W-1:0] o_used_q, o_used_d;
  logic              o_empty_q, o_empty_d;
  logic              o_last_q, o_last_d;

  logic out_free;
  logic in_fire;
  logic take_msg;
  logic take_tick;
  logic drain_step;
  logic drain_last;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign take_msg   = in_fire && !mode_i && (can_id_i != '0);
  assign take_tick  = in_fire && mode_i;
  assign drain_step = (state_q == ST_DRAIN) && out_free;
  assign drain_last = ({1'b0, idx_q} + USED_W'(1)) == fill_q;

  assign any_hit = |hits;

  // ---- cell row ----
  always_comb begin
    ctrl.id = can_id_i;
    if (take_msg) begin
      ctrl.op = CELL_MSG;
    end else if (drain_step) begin
      ctrl.op = CELL_SHIFT;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic        prev_valid;
    cidc_entry_t next_entry;
    if (g == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = cells[g-1].valid;
    end
    if (g == TABLE_ENTRIES - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = cells[g+1];
    end
    cidc_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .any_hit_i    (any_hit),
      .prev_valid_i (prev_valid),
      .next_i       (next_entry),
      .entry_o      (cells[g]),
      .hit_o        (hits[g])
    );
    assign valids[g] = cells[g].valid;
  end

  // ---- sequencer: next state ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_tick && (fill_q != '0)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_step && drain_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---- sequencer: outputs and counters ----
  always_comb begin
    fill_d      = fill_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_idx_d     = o_idx_q;
    o_id_d      = o_id_q;
    o_cnt_d     = o_cnt_q;
    o_used_d    = o_used_q;
    o_empty_d   = o_empty_q;
    o_last_d    = o_last_q;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (take_msg && !any_hit && (fill_q < USED_W'(TABLE_ENTRIES))) begin
          fill_d = fill_q + USED_W'(1);
        end
        if (take_tick && (fill_q == '0)) begin
          // empty window: one marker beat
          out_valid_d = 1'b1;
          o_idx_d     = '0;
          o_id_d      = '0;
          o_cnt_d     = '0;
          o_used_d    = '0;
          o_empty_d   = 1'b1;
          o_last_d    = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (drain_step) begin
          out_valid_d = 1'b1;
          o_idx_d     = idx_q;
          o_id_d      = cells[0].id;
          o_cnt_d     = cells[0].count;
          o_used_d    = fill_q;
          o_empty_d   = 1'b0;
          o_last_d    = drain_last;
          idx_d       = idx_q + IDX_W'(1);
          if (drain_last) begin
            fill_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_idx_q   <= o_idx_d;
    o_id_q    <= o_id_d;
    o_cnt_q   <= o_cnt_d;
    o_used_q  <= o_used_d;
    o_empty_q <= o_empty_d;
    o_last_q  <= o_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign entry_index_o  = o_idx_q;
  assign entry_id_o     = o_id_q;
  assign entry_count_o  = o_cnt_q;
  assign entries_used_o = o_used_q;
  assign empty_res_o    = o_empty_q;
  assign last_o         = o_last_q;

`ifndef SYNTHESIS
  // while idle, the number of filled cells matches the fill count
  a_fill_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ($countones(valids) == 32'(fill_q)))
    else $error("fill count disagrees with valid cells");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= USED_W'(TABLE_ENTRIES))
    else $error("fill count above table size");

  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && o_empty_q) |-> (o_last_q && (o_used_q == '0)))
    else $error("empty result not marked last");

  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drain_step && drain_last) |=> ((state_q == ST_IDLE) && (valids == '0)))
    else $error("table not clear after readout");
`endif

endmodule
